// ===== rtl/core/fat12_rdl_pkg.sv =====
// Package for the FAT12 root directory lookup block.
// Holds the item types, status codes, register indexes and fixed constants.
// No dependencies.
package fat12_rdl_pkg;

   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned COPY_W = 10;
   localparam int unsigned ENTRY_SHIFT = 4;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [7:0] MARK_DELETED = 8'hE5;
   localparam logic [7:0] MARK_END = 8'h00;
   localparam int unsigned ATTR_VOLUME_BIT = 3;

   localparam logic [63:0] NAME_BASE_RESET = 64'h2020202020202020;
   localparam logic [23:0] NAME_EXT_RESET = 24'h202020;
   localparam logic [17:0] FIRST_DATA_SECTOR_RESET = 18'd33;
   localparam logic [7:0] CLUSTER_SECTORS_RESET = 8'd1;
   localparam logic [15:0] ROOT_ENTRY_LIMIT_RESET = 16'd224;
   localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd512;

   typedef enum logic [2:0] {
      STATUS_CONTINUE = 3'd0,
      STATUS_FOUND = 3'd1,
      STATUS_END = 3'd2,
      STATUS_EXHAUSTED = 3'd3,
      STATUS_FINISHED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_NAME_BASE = 3'd0,
      REG_NAME_EXT = 3'd1,
      REG_FIRST_DATA_SECTOR = 3'd2,
      REG_CLUSTER_SECTORS = 3'd3,
      REG_ROOT_ENTRY_LIMIT = 3'd4,
      REG_BUFFER_LENGTH = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        first_entry;
      logic [63:0] entry_name;
      logic [23:0] entry_ext;
      logic [7:0]  attributes;
      logic [15:0] first_cluster;
      logic [31:0] size_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [31:0]       data_sector;
      logic [COPY_W-1:0] copy_length;
      logic [15:0]       entry_index;
   } rsp_type;

endpackage

// ===== rtl/core/fat12_root_dir_lookup.sv =====
// FAT12 root directory lookup: input register, compare and sector math, result register.
// Depends on fat12_rdl_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_item): one 32-byte root directory entry per
//   item, already split into fields. first_entry set starts a new search.
//   rsp channel (rsp_valid/rsp_ready/rsp_item): exactly one result item per entry,
//   in order: status, data sector of the start cluster, copy length, entry index.
//   csr port: APB-style, 64-bit data, register i at byte address 8*i; writes land
//   at the access cycle, pready is always high. Write only while the block is idle.
// Timing:
//   On acceptance the item is loaded into the input register; the result register
//   is then loaded from it through the compare and the 32x8 cluster multiply once
//   it is free. Throughput: one item per cycle while rsp_ready is high; the search state
//   (entry counter, finished flag) is updated as each item enters the result register.
// Reset:
//   Synchronous, active high. Clears both pipeline valid bits, the entry counter
//   and the finished flag, and loads the register defaults.
// Stall:
//   While rsp_ready is low the result holds; the input register still takes one
//   more item, after which req_ready drops until the result is taken.
module fat12_root_dir_lookup (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fat12_rdl_pkg::req_type                req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fat12_rdl_pkg::rsp_type                rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fat12_rdl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fat12_rdl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fat12_rdl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   localparam int unsigned CW = fat12_rdl_pkg::COPY_W;

   logic [63:0] name_base_ff;
   logic [23:0] name_ext_ff;
   logic [17:0] first_data_sector_ff;
   logic [7:0]  cluster_sectors_ff;
   logic [15:0] root_entry_limit_ff;
   logic [15:0] buffer_length_ff;

   logic                   s1_valid_ff;
   fat12_rdl_pkg::req_type s1_item_ff;
   logic                   rsp_valid_ff;
   fat12_rdl_pkg::rsp_type rsp_item_ff;
   fat12_rdl_pkg::rsp_type rsp_item_in;
   logic [15:0]            counter_ff;
   logic [15:0]            counter_in;
   logic                   finished_ff;
   logic                   finished_in;

   logic                         rsp_load;
   logic                         req_take;
   logic                         csr_write;
   fat12_rdl_pkg::reg_index_type csr_index;

   logic [15:0] idx;
   logic        fin_now;
   logic [12:0] sectors_rounded;
   logic [16:0] total;
   logic        name_match;
   logic [7:0]  first_byte;
   logic [31:0] cluster_off;
   logic [31:0] sector_prod;
   logic [31:0] sector;
   logic [CW-1:0] buf_cap;
   logic [CW-1:0] copy;

   assign rsp_load = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || rsp_load;
   assign req_take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = fat12_rdl_pkg::reg_index_type'(paddr[5:3]);

   always_comb begin
      unique case (csr_index)
         fat12_rdl_pkg::REG_NAME_BASE: prdata = name_base_ff;
         fat12_rdl_pkg::REG_NAME_EXT: prdata = {40'd0, name_ext_ff};
         fat12_rdl_pkg::REG_FIRST_DATA_SECTOR: prdata = {46'd0, first_data_sector_ff};
         fat12_rdl_pkg::REG_CLUSTER_SECTORS: prdata = {56'd0, cluster_sectors_ff};
         fat12_rdl_pkg::REG_ROOT_ENTRY_LIMIT: prdata = {48'd0, root_entry_limit_ff};
         fat12_rdl_pkg::REG_BUFFER_LENGTH: prdata = {48'd0, buffer_length_ff};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_base_ff <= fat12_rdl_pkg::NAME_BASE_RESET;
         name_ext_ff <= fat12_rdl_pkg::NAME_EXT_RESET;
         first_data_sector_ff <= fat12_rdl_pkg::FIRST_DATA_SECTOR_RESET;
         cluster_sectors_ff <= fat12_rdl_pkg::CLUSTER_SECTORS_RESET;
         root_entry_limit_ff <= fat12_rdl_pkg::ROOT_ENTRY_LIMIT_RESET;
         buffer_length_ff <= fat12_rdl_pkg::BUFFER_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            fat12_rdl_pkg::REG_NAME_BASE: name_base_ff <= pwdata;
            fat12_rdl_pkg::REG_NAME_EXT: name_ext_ff <= pwdata[23:0];
            fat12_rdl_pkg::REG_FIRST_DATA_SECTOR: first_data_sector_ff <= pwdata[17:0];
            fat12_rdl_pkg::REG_CLUSTER_SECTORS: cluster_sectors_ff <= pwdata[7:0];
            fat12_rdl_pkg::REG_ROOT_ENTRY_LIMIT: root_entry_limit_ff <= pwdata[15:0];
            fat12_rdl_pkg::REG_BUFFER_LENGTH: buffer_length_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // search state as seen by the entry in the input register
   always_comb begin
      idx = s1_item_ff.first_entry ? 16'd0 : counter_ff;
      fin_now = s1_item_ff.first_entry ? 1'b0 : finished_ff;
      sectors_rounded = 13'((17'(root_entry_limit_ff) + 17'd15) >> fat12_rdl_pkg::ENTRY_SHIFT);
      total = {sectors_rounded, 4'd0};
      first_byte = s1_item_ff.entry_name[63:56];
      name_match = (first_byte != fat12_rdl_pkg::MARK_DELETED)
         && !s1_item_ff.attributes[fat12_rdl_pkg::ATTR_VOLUME_BIT]
         && (s1_item_ff.entry_name == name_base_ff)
         && (s1_item_ff.entry_ext == name_ext_ff);
      cluster_off = {16'd0, s1_item_ff.first_cluster} - 32'd2;
      sector_prod = cluster_off * {24'd0, cluster_sectors_ff};
      sector = sector_prod + {14'd0, first_data_sector_ff};
      buf_cap = (buffer_length_ff > 16'(fat12_rdl_pkg::SECTOR_BYTES))
         ? CW'(fat12_rdl_pkg::SECTOR_BYTES) : buffer_length_ff[CW-1:0];
      copy = (s1_item_ff.size_bytes < 32'(buf_cap)) ? s1_item_ff.size_bytes[CW-1:0] : buf_cap;
   end

   always_comb begin
      rsp_item_in.status = fat12_rdl_pkg::STATUS_CONTINUE;
      rsp_item_in.data_sector = '0;
      rsp_item_in.copy_length = '0;
      rsp_item_in.entry_index = idx;
      counter_in = idx;
      finished_in = fin_now;
      if (fin_now) begin
         rsp_item_in.status = fat12_rdl_pkg::STATUS_FINISHED;
      end else if (total == 17'd0) begin
         rsp_item_in.status = fat12_rdl_pkg::STATUS_EXHAUSTED;
         finished_in = 1'b1;
      end else begin
         if (first_byte == fat12_rdl_pkg::MARK_END) begin
            rsp_item_in.status = fat12_rdl_pkg::STATUS_END;
         end else if (name_match) begin
            rsp_item_in.status = fat12_rdl_pkg::STATUS_FOUND;
            rsp_item_in.data_sector = sector;
            rsp_item_in.copy_length = copy;
         end else if (17'(idx) == total - 17'd1) begin
            rsp_item_in.status = fat12_rdl_pkg::STATUS_EXHAUSTED;
         end
         if (rsp_item_in.status != fat12_rdl_pkg::STATUS_CONTINUE) begin
            finished_in = 1'b1;
         end
         counter_in = idx + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff <= '0;
         finished_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            counter_ff <= counter_in;
            finished_ff <= finished_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && (rsp_item_in.status != fat12_rdl_pkg::STATUS_CONTINUE) |=> finished_ff)
      else $error("search did not end after a final status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load && (rsp_item_in.status == fat12_rdl_pkg::STATUS_FINISHED) |=> $stable(counter_ff))
      else $error("entry counter moved on an ignored item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status != fat12_rdl_pkg::STATUS_FOUND)
      |-> (rsp_item_ff.data_sector == 32'd0) && (rsp_item_ff.copy_length == '0))
      else $error("sector or length reported without a match");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_item_ff.copy_length) <= fat12_rdl_pkg::SECTOR_BYTES))
      else $error("copy length exceeds one sector");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");
`endif

endmodule
